>>> hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int DELAY_BITS  = 16;

    localparam logic [29:0] UNIT      = 30'd1000000000;
    localparam logic [29:0] HALF_UNIT = 30'd500000000;

    localparam logic [2:0] FN_TICK       = 3'd0;
    localparam logic [2:0] FN_RUN        = 3'd1;
    localparam logic [2:0] FN_STOP       = 3'd2;
    localparam logic [2:0] FN_ESTOP      = 3'd3;
    localparam logic [2:0] FN_QUERY      = 3'd4;
    localparam logic [2:0] FN_LOAD_DELAY = 3'd5;
    localparam logic [2:0] FN_LOAD_MOVE  = 3'd6;

    localparam logic [1:0] ST_STOPPED  = 2'd0;
    localparam logic [1:0] ST_RUN      = 2'd1;
    localparam logic [1:0] ST_STOPPING = 2'd2;
    localparam logic [1:0] ST_ESTOP    = 2'd3;

    localparam logic [2:0] CFG_FOLLOWER_RATE = 3'd0;
    localparam logic [2:0] CFG_X_IS_LEAD     = 3'd1;
    localparam logic [2:0] CFG_X_DIR_FORWARD = 3'd2;
    localparam logic [2:0] CFG_A_DIR_FORWARD = 3'd3;
    localparam logic [2:0] CFG_RAMP_LENGTH   = 3'd4;

    typedef struct packed {
        logic        stepped;
        logic        x_step;
        logic        a_step;
        logic [1:0]  run_status;
        logic [31:0] x_position;
        logic [31:0] a_position;
        logic [30:0] steps_remaining;
        logic [10:0] ramp_position;
    } tss_res_t;

    typedef struct packed {
        logic                  wr_en;
        logic [TABLE_AW-1:0]   wr_addr;
        logic [DELAY_BITS-1:0] wr_data;
        logic                  rd_en;
        logic [TABLE_AW-1:0]   rd_addr;
    } tss_mem_req_t;

endpackage

>>> hw/rtl/tss_delay_ram.sv
`timescale 1ns / 1ps

module tss_delay_ram
    import tss_pkg::*;
(
    input  logic                  clk,
    input  tss_mem_req_t          req,
    output logic [DELAY_BITS-1:0] rd_data
);

    logic [DELAY_BITS-1:0] mem [TABLE_DEPTH];
    logic [DELAY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/tss_state.sv
`timescale 1ns / 1ps

module tss_state
    import tss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [29:0]  cfg_data,
    input  logic         acc,
    input  logic [2:0]   func,
    input  logic [10:0]  table_index,
    input  logic [15:0]  delay_value,
    input  logic [30:0]  move_length,
    output tss_res_t     res,
    output tss_mem_req_t mem_req
);

    logic [29:0] follower_rate_reg;
    logic        x_is_lead_reg;
    logic        x_dir_forward_reg;
    logic        a_dir_forward_reg;
    logic [11:0] ramp_length_reg;

    logic [1:0]  run_state_reg, run_state_next;
    logic [30:0] remaining_reg, remaining_next;
    logic [10:0] ramp_index_reg, ramp_index_next;
    logic [30:0] phase_acc_reg, phase_acc_next;
    logic [31:0] x_count_reg, x_count_next;
    logic [31:0] a_count_reg, a_count_next;

    logic        active;
    logic [29:0] rate;
    logic [30:0] acc_sum;
    logic        follow_pulse;
    logic        xs, as;
    logic [30:0] rem_dec;
    logic [1:0]  st_mid;
    logic [10:0] idx_dec;
    logic        can_climb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follower_rate_reg <= '0;
            x_is_lead_reg     <= 1'b0;
            x_dir_forward_reg <= 1'b1;
            a_dir_forward_reg <= 1'b1;
            ramp_length_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FOLLOWER_RATE: follower_rate_reg <= cfg_data;
                CFG_X_IS_LEAD:     x_is_lead_reg     <= cfg_data[0];
                CFG_X_DIR_FORWARD: x_dir_forward_reg <= cfg_data[0];
                CFG_A_DIR_FORWARD: a_dir_forward_reg <= cfg_data[0];
                CFG_RAMP_LENGTH:   ramp_length_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // tick datapath
    always_comb
    begin
        active       = ((run_state_reg == ST_RUN) || (run_state_reg == ST_STOPPING))
                       && (remaining_reg != '0);
        rate         = (follower_rate_reg > UNIT) ? UNIT : follower_rate_reg;
        acc_sum      = phase_acc_reg + {1'b0, rate};
        follow_pulse = acc_sum > {1'b0, UNIT};
        xs           = x_is_lead_reg ? 1'b1 : follow_pulse;
        as           = x_is_lead_reg ? follow_pulse : 1'b1;
        rem_dec      = remaining_reg - 31'd1;
        st_mid       = ({20'd0, ramp_index_reg} > rem_dec) ? ST_STOPPING : run_state_reg;
        idx_dec      = (ramp_index_reg != '0) ? ramp_index_reg - 11'd1 : '0;
        can_climb    = (({1'b0, ramp_index_reg} + 12'd1) < ramp_length_reg)
                       && ({20'd0, ramp_index_reg} < rem_dec)
                       && (32'(ramp_index_reg) < 32'(TABLE_DEPTH - 1));
    end

    always_comb
    begin
        run_state_next  = run_state_reg;
        remaining_next  = remaining_reg;
        ramp_index_next = ramp_index_reg;
        phase_acc_next  = phase_acc_reg;
        x_count_next    = x_count_reg;
        a_count_next    = a_count_reg;

        case (func)
            FN_TICK:
            begin
                if (active)
                begin
                    remaining_next = rem_dec;
                    phase_acc_next = follow_pulse ? acc_sum - {1'b0, UNIT} : acc_sum;
                    if (xs)
                    begin
                        x_count_next = x_dir_forward_reg ? x_count_reg + 32'd1
                                                         : x_count_reg - 32'd1;
                    end
                    if (as)
                    begin
                        a_count_next = a_dir_forward_reg ? a_count_reg + 32'd1
                                                         : a_count_reg - 32'd1;
                    end
                    run_state_next = st_mid;
                    if (st_mid == ST_STOPPING)
                    begin
                        ramp_index_next = idx_dec;
                        if (idx_dec == '0)
                        begin
                            run_state_next = ST_STOPPED;
                        end
                    end
                    else if (can_climb)
                    begin
                        ramp_index_next = ramp_index_reg + 11'd1;
                    end
                end
            end
            FN_RUN:
            begin
                if (run_state_reg == ST_STOPPED)
                begin
                    phase_acc_next  = {1'b0, HALF_UNIT};
                    ramp_index_next = '0;
                    run_state_next  = ST_RUN;
                end
                else if (run_state_reg == ST_STOPPING)
                begin
                    run_state_next = ST_RUN;
                end
            end
            FN_STOP:
            begin
                if (run_state_reg == ST_RUN)
                begin
                    run_state_next = ST_STOPPING;
                end
            end
            FN_ESTOP:     run_state_next = ST_ESTOP;
            FN_LOAD_MOVE: remaining_next = move_length;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_state_reg  <= ST_STOPPED;
            remaining_reg  <= '0;
            ramp_index_reg <= '0;
            phase_acc_reg  <= {1'b0, HALF_UNIT};
            x_count_reg    <= '0;
            a_count_reg    <= '0;
        end
        else if (acc)
        begin
            run_state_reg  <= run_state_next;
            remaining_reg  <= remaining_next;
            ramp_index_reg <= ramp_index_next;
            phase_acc_reg  <= phase_acc_next;
            x_count_reg    <= x_count_next;
            a_count_reg    <= a_count_next;
        end
    end

    always_comb
    begin
        res.stepped         = (func == FN_TICK) && active;
        res.x_step          = res.stepped && xs;
        res.a_step          = res.stepped && as;
        res.run_status      = run_state_next;
        res.x_position      = x_count_next;
        res.a_position      = a_count_next;
        res.steps_remaining = remaining_next;
        res.ramp_position   = ramp_index_next;
    end

    // table read uses the index before this tick's update
    always_comb
    begin
        mem_req.wr_en   = acc && (func == FN_LOAD_DELAY)
                          && (32'(table_index) < 32'(TABLE_DEPTH));
        mem_req.wr_addr = table_index[TABLE_AW-1:0];
        mem_req.wr_data = delay_value[DELAY_BITS-1:0];
        mem_req.rd_en   = acc;
        mem_req.rd_addr = ramp_index_reg[TABLE_AW-1:0];
    end

endmodule

>>> hw/rtl/tss_pipe.sv
`timescale 1ns / 1ps

module tss_pipe
    import tss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  acc,
    input  tss_res_t              res,
    input  logic [DELAY_BITS-1:0] rd_data,
    input  logic                  out_stall,
    output logic                  in_stall,
    output logic                  out_valid,
    output tss_res_t              out_res,
    output logic [15:0]           out_delay
);

    logic        s1_valid_reg, s1_valid_next;
    tss_res_t    s1_reg;
    logic        s2_valid_reg, s2_valid_next;
    tss_res_t    s2_reg;
    logic [15:0] s2_delay_reg;
    logic        s1_move;

    // s1 waits on the table read; s2 is the output register
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;

    always_comb
    begin
        s1_valid_next = acc || (s1_valid_reg && !s1_move);
        s2_valid_next = s1_move || (s2_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= res;
        end
        if (s1_move)
        begin
            s2_reg       <= s1_reg;
            s2_delay_reg <= s1_reg.stepped ? 16'(rd_data) : 16'd0;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_res   = s2_reg;
    assign out_delay = s2_delay_reg;

endmodule

>>> hw/rtl/two_axis_step_sequencer.sv
`timescale 1ns / 1ps
// Path: a request is registered in s1 at acceptance while the delay table is read, then moves
// into the s2 output register, where out_valid rises; a stalled output holds s1 as well.
// Throughput: one request per cycle while in_stall is low; the state registers update at
// acceptance; the delay table read (one synchronous port) lands while the request is in s1.
// Reset: run state stopped, counts and ramp index zero, accumulator 500000000, registers
// at their defaults; delay table contents are undefined until written, no clearing pass.

module two_axis_step_sequencer
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [10:0] table_index,
    input  logic [15:0] delay_value,
    input  logic [30:0] move_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        x_step,
    output logic        a_step,
    output logic [15:0] delay_us,
    output logic [1:0]  run_status,
    output logic signed [31:0] x_position,
    output logic signed [31:0] a_position,
    output logic [30:0] steps_remaining,
    output logic [10:0] ramp_position
);

    logic                  acc;
    tss_res_t              res;
    tss_mem_req_t          mem_req;
    logic [DELAY_BITS-1:0] rd_data;
    tss_res_t              out_res;

    assign acc = in_valid && !in_stall;

    tss_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .acc         (acc),
        .func        (func),
        .table_index (table_index),
        .delay_value (delay_value),
        .move_length (move_length),
        .res         (res),
        .mem_req     (mem_req)
    );

    tss_delay_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    tss_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .res       (res),
        .rd_data   (rd_data),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_delay (delay_us)
    );

    assign x_step          = out_res.x_step;
    assign a_step          = out_res.a_step;
    assign run_status      = out_res.run_status;
    assign x_position      = out_res.x_position;
    assign a_position      = out_res.a_position;
    assign steps_remaining = out_res.steps_remaining;
    assign ramp_position   = out_res.ramp_position;

endmodule

>>> hw/rtl/tss_checker.sv
`timescale 1ns / 1ps

module tss_sva
    import tss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        x_step,
    input logic        a_step,
    input logic [15:0] delay_us,
    input logic [1:0]  run_status,
    input logic signed [31:0] x_position
);

    // a held output request keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_position))
        else $error("stalled output changed");

    // input side only backs up when the output register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // a nonzero delay comes only with a step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (delay_us != 16'd0) |-> x_step || a_step)
        else $error("delay without step");

    // emergency stop never steps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (run_status == ST_ESTOP) |-> !x_step && !a_step)
        else $error("step while emergency stopped");

endmodule

bind two_axis_step_sequencer tss_sva u_tss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_step     (x_step),
    .a_step     (a_step),
    .delay_us   (delay_us),
    .run_status (run_status),
    .x_position (x_position)
);

>>> tb/tss_checker.sv
`timescale 1ns / 1ps

module tss_checker
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [10:0] table_index,
    input  logic [15:0] delay_value,
    input  logic [30:0] move_length,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        x_step,
    input  logic        a_step,
    input  logic [15:0] delay_us,
    input  logic [1:0]  run_status,
    input  logic [31:0] x_position,
    input  logic [31:0] a_position,
    input  logic [30:0] steps_remaining,
    input  logic [10:0] ramp_position,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        x_step;
        logic        a_step;
        logic [15:0] delay_us;
        logic [1:0]  run_status;
        logic [31:0] x_position;
        logic [31:0] a_position;
        logic [30:0] steps_remaining;
        logic [10:0] ramp_position;
    } step_report_t;

    localparam logic [10:0] IDX_TOP = 11'd2047;
    localparam logic [31:0] UNIT32  = {2'b00, UNIT};

    // register copies
    logic [29:0] rate_cfg;
    logic        lead_is_x;
    logic        x_fwd;
    logic        a_fwd;
    logic [11:0] ramp_len;

    // motion state
    logic [1:0]  motion;
    logic [30:0] lead_left;
    logic [10:0] ramp_idx;
    logic [31:0] phase_acc;
    logic [31:0] x_count;
    logic [31:0] a_count;
    logic [DELAY_BITS-1:0] delay_mem [TABLE_DEPTH];

    step_report_t expected_q [$];
    step_report_t want;
    int           mismatches = 0;

    assign fail_count = mismatches;

    function automatic step_report_t advance(input logic [2:0] op, input logic [10:0] idx_in,
                                             input logic [15:0] dly_in,
                                             input logic [30:0] len_in);
        step_report_t rep;
        logic [31:0]  eff_rate;
        logic         carry;
        logic [11:0]  idx_next;
        rep = '0;
        case (op)
            FN_TICK:
            begin
                if ((motion == ST_RUN || motion == ST_STOPPING) && lead_left != 0)
                begin
                    eff_rate = (rate_cfg > UNIT) ? UNIT32 : {2'b00, rate_cfg};
                    lead_left = lead_left - 31'd1;
                    phase_acc = phase_acc + eff_rate;
                    carry = phase_acc > UNIT32;
                    if (carry)
                        phase_acc = phase_acc - UNIT32;
                    rep.x_step = lead_is_x ? 1'b1 : carry;
                    rep.a_step = lead_is_x ? carry : 1'b1;
                    if (rep.x_step)
                        x_count = x_fwd ? x_count + 32'd1 : x_count - 32'd1;
                    if (rep.a_step)
                        a_count = a_fwd ? a_count + 32'd1 : a_count - 32'd1;
                    rep.delay_us = 16'(delay_mem[ramp_idx]);
                    // close to the end of the move: ramp down
                    if (lead_left < {20'd0, ramp_idx})
                        motion = ST_STOPPING;
                    if (motion == ST_STOPPING)
                    begin
                        if (ramp_idx != 0)
                            ramp_idx = ramp_idx - 11'd1;
                        if (ramp_idx == 0)
                            motion = ST_STOPPED;
                    end
                    else
                    begin
                        idx_next = {1'b0, ramp_idx} + 12'd1;
                        if (idx_next < ramp_len && {20'd0, ramp_idx} < lead_left &&
                            int'(idx_next) < TABLE_DEPTH && ramp_idx < IDX_TOP)
                            ramp_idx = ramp_idx + 11'd1;
                    end
                end
            end
            FN_RUN:
            begin
                if (motion == ST_STOPPED)
                begin
                    phase_acc = {2'b00, HALF_UNIT};
                    ramp_idx = '0;
                    motion = ST_RUN;
                end
                else if (motion == ST_STOPPING)
                    motion = ST_RUN;
            end
            FN_STOP:
            begin
                if (motion == ST_RUN)
                    motion = ST_STOPPING;
            end
            FN_ESTOP:
                motion = ST_ESTOP;
            FN_LOAD_DELAY:
            begin
                if (int'(idx_in) < TABLE_DEPTH)
                    delay_mem[idx_in] = DELAY_BITS'(dly_in);
            end
            FN_LOAD_MOVE:
                lead_left = len_in;
            default:
                ;   // query and the spare code change nothing
        endcase
        rep.run_status      = motion;
        rep.x_position      = x_count;
        rep.a_position      = a_count;
        rep.steps_remaining = lead_left;
        rep.ramp_position   = ramp_idx;
        return rep;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_cfg   = '0;
            lead_is_x  = 1'b0;
            x_fwd      = 1'b1;
            a_fwd      = 1'b1;
            ramp_len   = '0;
            motion     = ST_STOPPED;
            lead_left  = '0;
            ramp_idx   = '0;
            phase_acc  = {2'b00, HALF_UNIT};
            x_count    = '0;
            a_count    = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FOLLOWER_RATE: rate_cfg  = cfg_data;
                    CFG_X_IS_LEAD:     lead_is_x = cfg_data[0];
                    CFG_X_DIR_FORWARD: x_fwd     = cfg_data[0];
                    CFG_A_DIR_FORWARD: a_fwd     = cfg_data[0];
                    CFG_RAMP_LENGTH:   ramp_len  = cfg_data[11:0];
                    default:           ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("x_step", 32'(want.x_step), 32'(x_step));
                    check_field("a_step", 32'(want.a_step), 32'(a_step));
                    check_field("delay_us", 32'(want.delay_us), 32'(delay_us));
                    check_field("run_status", 32'(want.run_status), 32'(run_status));
                    check_field("x_position", want.x_position, x_position);
                    check_field("a_position", want.a_position, a_position);
                    check_field("steps_remaining", 32'(want.steps_remaining),
                                32'(steps_remaining));
                    check_field("ramp_position", 32'(want.ramp_position), 32'(ramp_position));
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(advance(func, table_index, delay_value, move_length));
            pending <= expected_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tss_pkg::*;

    localparam logic [2:0] FN_SPARE       = 3'd7;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         TAIL_CYCLES    = 8;
    localparam int         RANDOM_ITEMS   = 1000;
    localparam int         PHASE_ITEMS    = 150;
    // ramp lengths never exceed this, so the ramp index stays inside the filled entries
    localparam int         FILL_ENTRIES   = 256;
    // everything but the emergency stop, which is sticky and kept for the end
    localparam logic [2:0] NOISE_OPS [7] = '{FN_TICK, FN_RUN, FN_STOP, FN_QUERY,
                                            FN_LOAD_DELAY, FN_LOAD_MOVE, FN_SPARE};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_FOLLOWER_RATE;
    logic [29:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = FN_QUERY;
    logic [10:0] table_index = '0;
    logic [15:0] delay_value = '0;
    logic [30:0] move_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        x_step;
    logic        a_step;
    logic [15:0] delay_us;
    logic [1:0]  run_status;
    logic signed [31:0] x_position;
    logic signed [31:0] a_position;
    logic [30:0] steps_remaining;
    logic [10:0] ramp_position;

    int fail_count;
    int pending;
    bit idling_on = 1'b1;
    int requests_sent = 0;
    int settings_used = 0;
    int func_hits [8] = '{default: 0};
    int stall_left = 0;
    int quiet_cycles = 0;

    two_axis_step_sequencer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .table_index     (table_index),
        .delay_value     (delay_value),
        .move_length     (move_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_step          (x_step),
        .a_step          (a_step),
        .delay_us        (delay_us),
        .run_status      (run_status),
        .x_position      (x_position),
        .a_position      (a_position),
        .steps_remaining (steps_remaining),
        .ramp_position   (ramp_position)
    );

    tss_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .table_index     (table_index),
        .delay_value     (delay_value),
        .move_length     (move_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_step          (x_step),
        .a_step          (a_step),
        .delay_us        (delay_us),
        .run_status      (run_status),
        .x_position      (x_position),
        .a_position      (a_position),
        .steps_remaining (steps_remaining),
        .ramp_position   (ramp_position),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idling_on && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] op, input logic [10:0] ti, input logic [15:0] dv,
                            input logic [30:0] ml);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        table_index <= ti;
        delay_value <= dv;
        move_length <= ml;
        requests_sent++;
        func_hits[op]++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_op(input logic [2:0] op);
        send_req(op, 11'($urandom), 16'($urandom), 31'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [29:0] rate, input logic lead, input logic xf,
                                  input logic af, input logic [11:0] rlen);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FOLLOWER_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_index <= CFG_X_IS_LEAD;
        cfg_data  <= 30'(lead);
        @(posedge clk);
        cfg_index <= CFG_X_DIR_FORWARD;
        cfg_data  <= 30'(xf);
        @(posedge clk);
        cfg_index <= CFG_A_DIR_FORWARD;
        cfg_data  <= 30'(af);
        @(posedge clk);
        cfg_index <= CFG_RAMP_LENGTH;
        cfg_data  <= 30'(rlen);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // one move: load, run, tick through it with commands mixed in; sometimes plain noise
    task automatic drive_move();
        int          n;
        int          r;
        logic [30:0] len;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_op(NOISE_OPS[$urandom_range(0, 6)]);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 9)
            len = 31'($urandom);
        else if (r < 20)
            len = 31'($urandom_range(41, 300));
        else
            len = 31'($urandom_range(1, 40));
        send_req(FN_LOAD_MOVE, 11'($urandom), 16'($urandom), len);
        if ($urandom_range(0, 3) == 0)
            send_op(FN_LOAD_DELAY);
        send_op(FN_RUN);
        n = ((len > 31'd300) ? 300 : int'(len)) + $urandom_range(0, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_op(FN_QUERY);
            else if (r < 4)
                send_op(FN_SPARE);
            else if (r < 7)
                send_op(FN_STOP);
            else if (r < 10)
                send_op(FN_RUN);
            else if (r < 12)
                send_req(FN_LOAD_MOVE, 11'($urandom), 16'($urandom),
                         31'($urandom_range(0, 30)));
            else if (r < 14)
                send_op(FN_LOAD_DELAY);
            else
                send_op(FN_TICK);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            send_op(FN_STOP);
            repeat ($urandom_range(0, 45)) send_op(FN_TICK);
        end
    endtask

    initial
    begin
        int          phase;
        int          random_start;
        int          target;
        int          r;
        logic [29:0] rate;
        logic [11:0] rlen;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low end of the delay table so no tick reads an unwritten entry
        for (int i = 0; i < FILL_ENTRIES; i++)
            send_req(FN_LOAD_DELAY, 11'(i), 16'($urandom), 31'($urandom));

        apply_settings(30'd600000000, 1'b1, 1'b1, 1'b0, 12'd4);
        send_op(FN_QUERY);
        send_op(FN_SPARE);
        send_op(FN_TICK);                   // idle tick while stopped
        send_op(FN_STOP);                   // stop from stopped does nothing
        send_req(FN_LOAD_MOVE, 11'd0, 16'd0, 31'd0);
        send_op(FN_RUN);
        send_op(FN_TICK);                   // running with nothing left
        send_req(FN_LOAD_MOVE, 11'h7FF, 16'hFFFF, 31'd6);
        repeat (3) send_op(FN_TICK);
        send_op(FN_STOP);
        send_op(FN_TICK);
        send_op(FN_RUN);                    // resume from stopping
        send_op(FN_RUN);                    // no effect while running
        repeat (2) send_op(FN_TICK);
        send_req(FN_LOAD_DELAY, 11'h7FF, 16'hFFFF, 31'd0);
        send_req(FN_LOAD_DELAY, 11'd0, 16'd0, 31'h7FFFFFFF);
        send_req(FN_LOAD_MOVE, 11'd0, 16'd0, 31'h7FFFFFFF);
        send_op(FN_TICK);
        send_op(FN_STOP);
        repeat (3) send_op(FN_TICK);

        random_start = requests_sent;
        phase = 0;
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase)
                0: apply_settings(30'd0, 1'b0, 1'b1, 1'b1, 12'd0);
                1: apply_settings(UNIT, 1'b1, 1'b0, 1'b0, 12'(FILL_ENTRIES));
                2: apply_settings(30'h3FFFFFFF, 1'b0, 1'b0, 1'b1, 12'(FILL_ENTRIES - 1));
                3: apply_settings(30'd1, 1'b1, 1'b1, 1'b0, 12'd1);
                default:
                begin
                    r = $urandom_range(0, 3);
                    case (r)
                        0: rate = 30'($urandom_range(0, 1000000000));
                        1: rate = 30'($urandom_range(0, 1000));
                        2: rate = UNIT - 30'($urandom_range(0, 1000));
                        default: rate = 30'($urandom);
                    endcase
                    rlen = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, FILL_ENTRIES))
                                                        : 12'($urandom_range(0, 40));
                    apply_settings(rate, 1'($urandom), 1'($urandom), 1'($urandom), rlen);
                end
            endcase
            if (requests_sent - random_start > RANDOM_ITEMS - 200)
                idling_on <= 1'b0;
            else
                idling_on <= ($urandom_range(0, 4) != 0);
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target)
                drive_move();
            phase++;
        end

        // emergency stop is sticky, so it closes the run
        idling_on <= 1'b0;
        send_req(FN_LOAD_MOVE, 11'd0, 16'd0, 31'd20);
        send_op(FN_RUN);
        send_op(FN_TICK);
        send_op(FN_ESTOP);
        repeat (2) send_op(FN_TICK);
        send_op(FN_RUN);
        send_op(FN_STOP);
        send_op(FN_TICK);
        send_op(FN_QUERY);

        drain();
        $display("Sent %0d requests: %0d ticks, %0d move loads, %0d delay loads, %0d settings.",
                 requests_sent, func_hits[FN_TICK], func_hits[FN_LOAD_MOVE],
                 func_hits[FN_LOAD_DELAY], settings_used);
        $display("Covered ramp lengths 0 to %0d over a filled table, rate clamp and estop.",
                 FILL_ENTRIES);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
